// ----- rtl/core/ebas_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ebas_pkg;

   // request operation codes
   localparam logic OP_CHOOSE = 1'b0;
   localparam logic OP_REWARD = 1'b1;

   // register indexes
   localparam logic CSR_ARM_COUNT     = 1'b0;
   localparam logic CSR_LEARNING_RATE = 1'b1;

   // fixed-point constants
   localparam int DIVIDEND_W = 37;
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;
   localparam logic [32:0] EXP_LIMIT = 33'h0_0010_0000;
   localparam logic [3:0] TERM_COUNT = 4'd10;
   localparam logic [31:0] WEIGHT_ONE = 32'h0001_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_MAX_RD,
      ST_MAX_CMP,
      ST_SUM_RD,
      ST_SUM_EXP,
      ST_SUM_WAIT,
      ST_THR,
      ST_SEL_RD,
      ST_SEL_EXP,
      ST_SEL_WAIT,
      ST_PROB,
      ST_PEN,
      ST_DIV_WAIT
   } ctrl_state_type;

   typedef enum logic [2:0] {
      EXP_IDLE,
      EXP_MUL,
      EXP_DIV,
      EXP_FIX,
      EXP_SQR,
      EXP_DONE
   } exp_phase_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic idx_clear;
      logic idx_inc;
      logic max_step;
      logic sum_add;
      logic exp_start;
      logic thr_load;
      logic sel_step;
      logic div_start;
      logic finish;
   } ebas_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_reward;
      logic idx_last;
      logic exp_done;
      logic div_done;
      logic sel_hit;
   } ebas_stat_type;

   // floor(2^31 / k) for the series divisors
   function automatic logic [31:0] recip_q31(input logic [3:0] k);
      logic [31:0] m;
      unique case (k)
         4'd1:    m = 32'd2147483648;
         4'd2:    m = 32'd1073741824;
         4'd3:    m = 32'd715827882;
         4'd4:    m = 32'd536870912;
         4'd5:    m = 32'd429496729;
         4'd6:    m = 32'd357913941;
         4'd7:    m = 32'd306783378;
         4'd8:    m = 32'd268435456;
         4'd9:    m = 32'd238609294;
         4'd10:   m = 32'd214748364;
         default: m = 32'd0;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ebas_exp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ebas_exp import ebas_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [32:0] x,
   output logic             done,
   output logic [16:0]      e
);

   exp_phase_type phase_ff, phase_in;
   logic [30:0] y_ff, y_in;
   logic [30:0] r_ff, r_in;
   logic [61:0] p_ff, p_in;
   logic [30:0] v_ff, v_in;
   logic [62:0] t_ff, t_in;
   logic [3:0]  k_ff, k_in;
   logic [1:0]  s_ff, s_in;

   logic [30:0] q_est;
   logic [34:0] qk;
   logic [34:0] rem;
   logic [30:0] q_fix;
   logic [61:0] sq;
   logic [31:0] rounded;

   // reciprocal divide by the term index, one correction step
   assign q_est = t_ff[61:31];
   assign qk    = 35'(q_est) * 35'(k_ff);
   assign rem   = {4'd0, v_ff} - qk;
   assign q_fix = (rem >= 35'(k_ff)) ? q_est + 31'd1 : q_est;
   assign sq    = r_ff * r_ff;

   // round Q1.30 to Q1.16
   assign rounded = {1'b0, r_ff} + 32'h0000_2000;
   assign e       = rounded[30:14];
   assign done    = (phase_ff == EXP_DONE);

   // series sequencer
   always_comb begin
      phase_in = phase_ff;
      y_in     = y_ff;
      r_in     = r_ff;
      p_in     = p_ff;
      v_in     = v_ff;
      t_in     = t_ff;
      k_in     = k_ff;
      s_in     = s_ff;
      unique case (phase_ff)
         EXP_IDLE: begin
            if (start) begin
               if (x > EXP_LIMIT) begin
                  r_in     = '0;
                  phase_in = EXP_DONE;
               end else begin
                  y_in     = {x[20:0], 10'd0};
                  r_in     = Q30_ONE;
                  k_in     = TERM_COUNT;
                  s_in     = '0;
                  phase_in = EXP_MUL;
               end
            end
         end
         EXP_MUL: begin
            p_in     = y_ff * r_ff;
            phase_in = EXP_DIV;
         end
         EXP_DIV: begin
            v_in     = p_ff[60:30];
            t_in     = p_ff[60:30] * recip_q31(k_ff);
            phase_in = EXP_FIX;
         end
         EXP_FIX: begin
            r_in = Q30_ONE - q_fix;
            if (k_ff == 4'd1) begin
               phase_in = EXP_SQR;
            end else begin
               k_in     = k_ff - 4'd1;
               phase_in = EXP_MUL;
            end
         end
         EXP_SQR: begin
            r_in = sq[60:30];
            s_in = s_ff + 2'd1;
            if (s_ff == 2'd3) begin
               phase_in = EXP_DONE;
            end
         end
         EXP_DONE: begin
            phase_in = EXP_IDLE;
         end
         default: begin
            phase_in = EXP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= EXP_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff <= y_in;
      r_ff <= r_in;
      p_ff <= p_in;
      v_ff <= v_in;
      t_ff <= t_in;
      k_ff <= k_in;
      s_ff <= s_in;
   end

endmodule
`default_nettype wire

// ----- rtl/core/ebas_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ebas_div import ebas_pkg::*; #(
   parameter int DV_W = 21
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DV_W-1:0]       divisor,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DV_W-1:0]       rem_ff;
   logic [DV_W-1:0]       div_ff;

   logic [DV_W:0]         rem_sh;
   logic                  ge;

   // restoring step, one quotient bit a cycle
   assign rem_sh = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign ge     = rem_sh >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIVIDEND_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], ge};
         rem_ff <= ge ? DV_W'(rem_sh - {1'b0, div_ff}) : rem_sh[DV_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ----- rtl/core/ebas_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ebas_dp import ebas_pkg::*; #(
   parameter int MAX_ARMS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ebas_cmd_type cmd,
   output ebas_stat_type     stat,
   input  wire logic         req_op,
   input  wire logic [15:0]  req_random_value,
   input  wire logic [3:0]   req_arm,
   input  wire logic [16:0]  req_feedback,
   input  wire logic         csr_write_enable,
   input  wire logic         csr_index,
   input  wire logic [15:0]  csr_write_data,
   output logic              rsp_valid,
   output logic [3:0]        rsp_chosen_arm,
   output logic [16:0]       rsp_chosen_probability,
   output logic signed [31:0] rsp_updated_weight,
   output logic              rsp_saturated
);

   localparam int IDX_W = $clog2(MAX_ARMS);
   localparam int SUM_W = IDX_W + 17;
   localparam logic signed [38:0] NW_MIN = -39'sd2147483648;

   // configuration
   logic [4:0]  arm_count_ff;
   logic [15:0] lr_ff;

   // captured request
   logic        op_ff;
   logic [15:0] rnd_ff;
   logic [3:0]  arm_ff;
   logic [16:0] fb_ff;

   // weight store
   logic [31:0]         mem [MAX_ARMS];
   logic [MAX_ARMS-1:0] valid_ff;
   logic [31:0]         rdata_ff;
   logic                rvalid_ff;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;

   logic [IDX_W-1:0]    idx_ff;
   logic [IDX_W-1:0]    last_idx;
   logic signed [31:0]  w_cur;
   logic signed [31:0]  max_ff;
   logic [SUM_W-1:0]    sum_ff, run_ff, thr_ff;
   logic [SUM_W-1:0]    run_sum;
   logic [SUM_W+15:0]   thr_prod;
   logic [IDX_W-1:0]    pick_ff;
   logic [16:0]         e_pick_ff;
   logic signed [31:0]  pick_w_ff;
   logic [16:0]         last_prob_ff;
   logic signed [31:0]  last_w_ff;

   logic                rsp_valid_ff;
   logic [3:0]          rsp_arm_ff;
   logic [16:0]         rsp_prob_ff;
   logic signed [31:0]  rsp_weight_ff;
   logic                rsp_sat_ff;

   // units
   logic [32:0]           exp_x;
   logic                  exp_done;
   logic [16:0]           exp_e;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [SUM_W-1:0]      div_divisor;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] div_quo;

   logic [16:0]           fb_cl;
   logic [16:0]           miss;
   logic [32:0]           pen_prod;
   logic signed [38:0]    nw_wide;
   logic                  nw_sat;
   logic signed [31:0]    nw;
   logic [16:0]           prob;

   // last arm in use
   always_comb begin
      int n;
      if (arm_count_ff == 5'd0) begin
         n = 1;
      end else if (int'(arm_count_ff) > MAX_ARMS) begin
         n = MAX_ARMS;
      end else begin
         n = int'(arm_count_ff);
      end
      last_idx = IDX_W'(n - 1);
   end

   // weight of the arm under the walk; unwritten entries read as one
   assign w_cur = rvalid_ff ? $signed(rdata_ff) : $signed(WEIGHT_ONE);
   assign exp_x = {max_ff[31], max_ff} - {w_cur[31], w_cur};

   assign run_sum  = run_ff + SUM_W'(exp_e);
   assign thr_prod = rnd_ff * sum_ff;

   // penalty numerator and divider operands
   assign fb_cl        = (fb_ff > 17'd65536) ? 17'd65536 : fb_ff;
   assign miss         = 17'd65536 - fb_cl;
   assign pen_prod     = lr_ff * miss;
   assign div_dividend = (op_ff == OP_REWARD) ? {pen_prod, 4'd0} :
                                                {4'd0, e_pick_ff, 16'd0};
   assign div_divisor  = (op_ff == OP_REWARD) ? SUM_W'(last_prob_ff) : sum_ff;

   // weight update with floor at the minimum
   assign nw_wide = $signed({{7{last_w_ff[31]}}, last_w_ff}) - $signed({2'b00, div_quo});
   assign nw_sat  = nw_wide <= NW_MIN;
   assign nw      = nw_sat ? $signed(32'h8000_0000) : nw_wide[31:0];
   assign prob    = (div_quo == '0) ? 17'd1 : div_quo[16:0];

   assign wr_en   = cmd.finish && (op_ff == OP_REWARD) && (int'(arm_ff) < MAX_ARMS);
   assign wr_addr = IDX_W'(arm_ff);

   ebas_exp u_exp (
      .clock (clock),
      .reset (reset),
      .start (cmd.exp_start),
      .x     (exp_x),
      .done  (exp_done),
      .e     (exp_e)
   );

   ebas_div #(
      .DV_W (SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // weight memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= nw;
      end
      rdata_ff <= mem[idx_ff];
   end

   // control state: config, valid bits, remembered pick, result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         arm_count_ff <= 5'd16;
         lr_ff        <= 16'd4096;
         valid_ff     <= '0;
         rvalid_ff    <= 1'b0;
         last_prob_ff <= 17'd65536;
         last_w_ff    <= $signed(WEIGHT_ONE);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_ARM_COUNT:     arm_count_ff <= csr_write_data[4:0];
               CSR_LEARNING_RATE: lr_ff        <= csr_write_data;
               default:           lr_ff        <= lr_ff;
            endcase
         end
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rvalid_ff    <= valid_ff[idx_ff];
         rsp_valid_ff <= cmd.finish;
         if (cmd.finish && op_ff == OP_CHOOSE) begin
            last_prob_ff <= prob;
            last_w_ff    <= pick_w_ff;
         end
      end
   end

   // walk registers and result payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_op;
         rnd_ff <= req_random_value;
         arm_ff <= req_arm;
         fb_ff  <= req_feedback;
         idx_ff <= '0;
         sum_ff <= '0;
      end
      if (cmd.idx_clear) begin
         idx_ff <= '0;
      end
      if (cmd.idx_inc) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
      if (cmd.max_step && (idx_ff == '0 || w_cur > max_ff)) begin
         max_ff <= w_cur;
      end
      if (cmd.sum_add) begin
         sum_ff <= sum_ff + SUM_W'(exp_e);
      end
      if (cmd.thr_load) begin
         thr_ff <= thr_prod[SUM_W+15:16];
         run_ff <= '0;
         idx_ff <= '0;
      end
      if (cmd.sel_step) begin
         run_ff    <= run_sum;
         pick_ff   <= idx_ff;
         pick_w_ff <= w_cur;
         e_pick_ff <= (run_sum > thr_ff) ? exp_e : 17'd0;
      end
      if (cmd.finish) begin
         if (op_ff == OP_REWARD) begin
            rsp_arm_ff    <= 4'd0;
            rsp_prob_ff   <= last_prob_ff;
            rsp_weight_ff <= nw;
            rsp_sat_ff    <= nw_sat;
         end else begin
            rsp_arm_ff    <= 4'(pick_ff);
            rsp_prob_ff   <= prob;
            rsp_weight_ff <= '0;
            rsp_sat_ff    <= 1'b0;
         end
      end
   end

   assign stat.is_reward = (op_ff == OP_REWARD);
   assign stat.idx_last  = (idx_ff == last_idx);
   assign stat.exp_done  = exp_done;
   assign stat.div_done  = div_done;
   assign stat.sel_hit   = run_sum > thr_ff;

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_chosen_arm         = rsp_arm_ff;
   assign rsp_chosen_probability = rsp_prob_ff;
   assign rsp_updated_weight     = rsp_weight_ff;
   assign rsp_saturated          = rsp_sat_ff;

endmodule
`default_nettype wire

// ----- rtl/core/ebas_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ebas_ctrl import ebas_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   output ebas_cmd_type       cmd,
   input  wire ebas_stat_type stat
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequencing of the arm walks
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff) inside
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = stat.is_reward ? ST_PEN : ST_MAX_RD;
         end
         ST_MAX_RD: begin
            state_in = ST_MAX_CMP;
         end
         ST_MAX_CMP: begin
            cmd.max_step = 1'b1;
            if (stat.idx_last) begin
               cmd.idx_clear = 1'b1;
               state_in      = ST_SUM_RD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_MAX_RD;
            end
         end
         ST_SUM_RD: begin
            state_in = ST_SUM_EXP;
         end
         ST_SUM_EXP: begin
            cmd.exp_start = 1'b1;
            state_in      = ST_SUM_WAIT;
         end
         ST_SUM_WAIT: begin
            if (stat.exp_done) begin
               cmd.sum_add = 1'b1;
               if (stat.idx_last) begin
                  state_in = ST_THR;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_SUM_RD;
               end
            end
         end
         ST_THR: begin
            cmd.thr_load = 1'b1;
            state_in     = ST_SEL_RD;
         end
         ST_SEL_RD: begin
            state_in = ST_SEL_EXP;
         end
         ST_SEL_EXP: begin
            cmd.exp_start = 1'b1;
            state_in      = ST_SEL_WAIT;
         end
         ST_SEL_WAIT: begin
            if (stat.exp_done) begin
               cmd.sel_step = 1'b1;
               if (stat.sel_hit || stat.idx_last) begin
                  state_in = ST_PROB;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_SEL_RD;
               end
            end
         end
         ST_PROB, ST_PEN: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (stat.div_done) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule
`default_nettype wire

// ----- rtl/core/exp3_bandit_arm_selector.sv -----
`timescale 1ns / 1ps
`default_nettype none
// a reward request is paced by the divider, which makes one quotient bit per cycle
// a choose request is paced by the iterative exp unit, which runs for each arm in use
// (series terms, then four squarings), and by the divider
// one request at a time; a new request is taken the cycle busy falls
// results are a one-cycle strobe on rsp_valid and the receiver cannot stall
// reset: synchronous; all weights read 1.0, registers return to 16 arms and eta 1.0
module exp3_bandit_arm_selector import ebas_pkg::*; #(
   parameter int MAX_ARMS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire logic         req_op,
   input  wire logic [15:0]  req_random_value,
   input  wire logic [3:0]   req_arm,
   input  wire logic [16:0]  req_feedback,
   output logic              rsp_valid,
   output logic [3:0]        rsp_chosen_arm,
   output logic [16:0]       rsp_chosen_probability,
   output logic signed [31:0] rsp_updated_weight,
   output logic              rsp_saturated,
   input  wire logic         csr_write_enable,
   input  wire logic         csr_index,
   input  wire logic [15:0]  csr_write_data
);

   ebas_cmd_type  cmd;
   ebas_stat_type stat;

   // sequencer
   ebas_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   // weights, exp unit, divider
   ebas_dp #(
      .MAX_ARMS (MAX_ARMS)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .stat                   (stat),
      .req_op                 (req_op),
      .req_random_value       (req_random_value),
      .req_arm                (req_arm),
      .req_feedback           (req_feedback),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data),
      .rsp_valid              (rsp_valid),
      .rsp_chosen_arm         (rsp_chosen_arm),
      .rsp_chosen_probability (rsp_chosen_probability),
      .rsp_updated_weight     (rsp_updated_weight),
      .rsp_saturated          (rsp_saturated)
   );

`ifndef SYNTHESIS
   // a result only follows a request in flight
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a request in flight");

   // one result per request
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back results");

   // probability is clamped to at least one lsb
   a_prob_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_chosen_probability != 17'd0)
      else $error("zero probability reported");

   // saturation flag matches the floored weight
   a_sat_weight: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |-> rsp_updated_weight == $signed(32'h8000_0000))
      else $error("saturated weight not at minimum");
`endif

endmodule
`default_nettype wire
